// ===== rtl/idm_pkg.sv =====
// Shared constants, action codes and control types for the 128-bit divider.
package idm_pkg;

    localparam int unsigned OPERAND_BITS_DEF = 128;
    localparam int unsigned WORD_W           = 64;
    localparam int unsigned S_DATA_W         = 4 * WORD_W;
    localparam int unsigned M_DATA_W         = 2 * WORD_W;
    localparam int unsigned ACTION_W         = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UQUO = 2'd0,
        ACT_SQUO = 2'd1,
        ACT_UREM = 2'd2,
        ACT_SREM = 2'd3
    } action_t;

    // Per-beat control that rides alongside the operands down the cell chain.
    typedef struct packed {
        logic want_rem;
        logic neg_quo;
    } ctl_t;

endpackage

// ===== rtl/idm_prep.sv =====
// Input stage: operand trim, sign handling and action decode.
module idm_prep #(
    parameter int unsigned OPERAND_BITS = idm_pkg::OPERAND_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  idm_pkg::action_t              in_action,
    input  logic [idm_pkg::M_DATA_W-1:0]  in_dividend,
    input  logic [idm_pkg::M_DATA_W-1:0]  in_divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output idm_pkg::ctl_t                 out_ctl,
    output logic [OPERAND_BITS-1:0]       out_rem,
    output logic [OPERAND_BITS-1:0]       out_aq,
    output logic [OPERAND_BITS-1:0]       out_dvs
);
    import idm_pkg::*;

    logic                    valid_reg;
    ctl_t                    ctl_reg, ctl_next;
    logic [OPERAND_BITS-1:0] aq_reg, aq_next;
    logic [OPERAND_BITS-1:0] dvs_reg, dvs_next;
    logic [OPERAND_BITS-1:0] a_raw, b_raw;
    logic                    is_signed;
    logic                    neg_a, neg_b;

    assign in_ready = !valid_reg || out_ready;
    assign a_raw    = in_dividend[OPERAND_BITS-1:0];
    assign b_raw    = in_divisor[OPERAND_BITS-1:0];

    always_comb begin
        unique case (in_action)
            ACT_UQUO: begin
                is_signed         = 1'b0;
                ctl_next.want_rem = 1'b0;
            end
            ACT_SQUO: begin
                is_signed         = 1'b1;
                ctl_next.want_rem = 1'b0;
            end
            ACT_UREM: begin
                is_signed         = 1'b0;
                ctl_next.want_rem = 1'b1;
            end
            default: begin
                is_signed         = 1'b1;
                ctl_next.want_rem = 1'b1;
            end
        endcase
        neg_a            = is_signed && a_raw[OPERAND_BITS-1];
        neg_b            = is_signed && b_raw[OPERAND_BITS-1];
        ctl_next.neg_quo = neg_a ^ neg_b;
        // most negative value negates to itself and reads as 2^(N-1) unsigned
        aq_next  = neg_a ? (~a_raw + 1'b1) : a_raw;
        dvs_next = neg_b ? (~b_raw + 1'b1) : b_raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg <= ctl_next;
            aq_reg  <= aq_next;
            dvs_reg <= dvs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = '0;
    assign out_aq    = aq_reg;
    assign out_dvs   = dvs_reg;

endmodule

// ===== rtl/idm_cell.sv =====
// One restoring-division cell: resolves one quotient bit per beat.
module idm_cell #(
    parameter int unsigned OPERAND_BITS = idm_pkg::OPERAND_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  idm_pkg::ctl_t           in_ctl,
    input  logic [OPERAND_BITS-1:0] in_rem,
    input  logic [OPERAND_BITS-1:0] in_aq,
    input  logic [OPERAND_BITS-1:0] in_dvs,
    output logic                    out_valid,
    input  logic                    out_ready,
    output idm_pkg::ctl_t           out_ctl,
    output logic [OPERAND_BITS-1:0] out_rem,
    output logic [OPERAND_BITS-1:0] out_aq,
    output logic [OPERAND_BITS-1:0] out_dvs
);
    import idm_pkg::*;

    logic                    valid_reg;
    ctl_t                    ctl_reg;
    logic [OPERAND_BITS-1:0] rem_reg, rem_next;
    logic [OPERAND_BITS-1:0] aq_reg, aq_next;
    logic [OPERAND_BITS-1:0] dvs_reg;
    logic [OPERAND_BITS-1:0] shifted;
    logic [OPERAND_BITS:0]   diff;
    logic                    fits;

    assign in_ready = !valid_reg || out_ready;

    // aq holds the unused dividend bits on top and finished quotient bits below
    always_comb begin
        shifted  = {in_rem[OPERAND_BITS-2:0], in_aq[OPERAND_BITS-1]};
        diff     = {in_rem[OPERAND_BITS-1], shifted} - {1'b0, in_dvs};
        fits     = !diff[OPERAND_BITS];
        rem_next = fits ? diff[OPERAND_BITS-1:0] : shifted;
        aq_next  = {in_aq[OPERAND_BITS-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            aq_reg  <= aq_next;
            dvs_reg <= in_dvs;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_aq    = aq_reg;
    assign out_dvs   = dvs_reg;

endmodule

// ===== rtl/int128_divide_modulo.sv =====
// Pipelined 128-bit restoring divider: unsigned/signed quotient or remainder.
//
// Usage: one operand pair per beat on the s_ channel, the action code on
// s_tuser; one 128-bit answer per beat on the m_ channel, in input order.
// The datapath is a chain of OPERAND_BITS identical cells, each resolving one
// quotient bit with one compare/subtract, behind an input stage that trims
// operands and takes magnitudes in the signed actions.
// Path: the input stage loads on the accepting edge, each cell then registers
// its result in turn, and the output register drives m_tvalid.
// Throughput: one beat per cycle unless the receiver stalls; each occupied cell holds a different item.
// Stalls: each stage has its own valid bit and moves when the next stage is
// empty or moving, so a stalled receiver holds the output register, the
// bubbles ahead of it fill up, and s_tready drops only once every stage is
// occupied.
// Zero divisor: quotient is all ones (1 for a signed quotient with negative
// dividend), remainder is the dividend magnitude.
// Reset clears all valid bits; no clearing pass, ready again on the next cycle.
module int128_divide_modulo #(
    parameter int unsigned OPERAND_BITS = idm_pkg::OPERAND_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dividend_lo, dividend_hi, divisor_lo, divisor_hi
    input  logic [idm_pkg::S_DATA_W-1:0]  s_tdata,
    // action
    input  logic [idm_pkg::ACTION_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // answer_lo, answer_hi
    output logic [idm_pkg::M_DATA_W-1:0]  m_tdata
);
    import idm_pkg::*;

    logic                    valid_w [0:OPERAND_BITS];
    logic                    ready_w [0:OPERAND_BITS];
    ctl_t                    ctl_w   [0:OPERAND_BITS];
    logic [OPERAND_BITS-1:0] rem_w   [0:OPERAND_BITS];
    logic [OPERAND_BITS-1:0] aq_w    [0:OPERAND_BITS];
    logic [OPERAND_BITS-1:0] dvs_w   [0:OPERAND_BITS];

    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg, m_data_next;
    logic [OPERAND_BITS-1:0] quo;
    logic [OPERAND_BITS-1:0] ans;
    logic                    out_ready;

    idm_prep #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (action_t'(s_tuser)),
        .in_dividend (s_tdata[M_DATA_W-1:0]),
        .in_divisor  (s_tdata[S_DATA_W-1:M_DATA_W]),
        .out_valid   (valid_w[0]),
        .out_ready   (ready_w[0]),
        .out_ctl     (ctl_w[0]),
        .out_rem     (rem_w[0]),
        .out_aq      (aq_w[0]),
        .out_dvs     (dvs_w[0])
    );

    for (genvar k = 0; k < OPERAND_BITS; k++) begin : g_cell
        idm_cell #(
            .OPERAND_BITS (OPERAND_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[k]),
            .in_ready  (ready_w[k]),
            .in_ctl    (ctl_w[k]),
            .in_rem    (rem_w[k]),
            .in_aq     (aq_w[k]),
            .in_dvs    (dvs_w[k]),
            .out_valid (valid_w[k+1]),
            .out_ready (ready_w[k+1]),
            .out_ctl   (ctl_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_aq    (aq_w[k+1]),
            .out_dvs   (dvs_w[k+1])
        );
    end

    assign out_ready             = !m_valid_reg || m_tready;
    assign ready_w[OPERAND_BITS] = out_ready;

    always_comb begin
        quo = aq_w[OPERAND_BITS];
        if (ctl_w[OPERAND_BITS].want_rem) begin
            ans = rem_w[OPERAND_BITS];
        end else if (ctl_w[OPERAND_BITS].neg_quo) begin
            ans = ~quo + 1'b1;
        end else begin
            ans = quo;
        end
        m_data_next                   = '0;
        m_data_next[OPERAND_BITS-1:0] = ans;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= valid_w[OPERAND_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && valid_w[OPERAND_BITS]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // input side can only block when the receiver is holding the output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

    // restoring invariant: final remainder below a nonzero divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_w[OPERAND_BITS] |->
            (rem_w[OPERAND_BITS] < dvs_w[OPERAND_BITS]) ||
            (dvs_w[OPERAND_BITS] == '0))
        else $error("remainder not below divisor");

    // zero divisor always yields an all-ones raw quotient
    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_w[OPERAND_BITS] && (dvs_w[OPERAND_BITS] == '0)) |->
            (aq_w[OPERAND_BITS] == '1))
        else $error("zero divisor quotient not all ones");

    // answer bits above the operand width stay clear
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg >> OPERAND_BITS) == '0))
        else $error("answer bits above operand width set");
`endif

endmodule
